// ===== sv/gtl_pkg.sv =====
package gtl_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LEFT_EDGE         = 3'd0,
        CFG_RIGHT_EDGE        = 3'd1,
        CFG_BOTTOM_EDGE       = 3'd2,
        CFG_NARROW_CELL_WIDTH = 3'd3,
        CFG_WIDE_CELL_WIDTH   = 3'd4,
        CFG_LINE_HEIGHT       = 3'd5,
        CFG_ASCII_FONT_ROW    = 3'd6
    } cfg_reg_e;

    localparam int CFG_DATA_W = 8;

    // Register reset values
    localparam logic [7:0] RST_LEFT_EDGE     = 8'd0;
    localparam logic [7:0] RST_RIGHT_EDGE    = 8'd159;
    localparam logic [7:0] RST_BOTTOM_EDGE   = 8'd95;
    localparam logic [4:0] RST_NARROW_WIDTH  = 5'd6;
    localparam logic [4:0] RST_WIDE_WIDTH    = 5'd12;
    localparam logic [5:0] RST_LINE_HEIGHT   = 6'd12;
    localparam logic [7:0] RST_ASCII_ROW     = 8'd163;

    // Byte codes
    localparam logic [7:0] BYTE_END     = 8'h00;
    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_FIRST  = 8'h21;
    localparam logic [7:0] GB_BASE      = 8'hA1;

    // Cursor steps
    localparam logic [7:0] NARROW_STEP = 8'd6;
    localparam logic [7:0] WIDE_STEP   = 8'd12;

    // Font geometry
    localparam int GLYPH_BYTES = 18;
    localparam int FONT_COLS   = 94;
    localparam int ROW_BYTES   = FONT_COLS * GLYPH_BYTES;

    typedef struct packed {
        logic       first_of_string;
        logic [7:0] start_x;
        logic [7:0] start_y;
        logic [7:0] text_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [15:0] char_code;
        logic        is_wide;
        logic        blank_glyph;
        logic [17:0] glyph_offset;
        logic        halted;
    } out_item_t;

    // Offset of a glyph from zero-based row and column in the font
    function automatic logic [17:0] glyph_offset_f(input logic [6:0] row_idx,
                                                   input logic [6:0] col_idx);
        logic [17:0] row_term;
        logic [17:0] col_term;
        row_term = 18'(row_idx) * 18'(ROW_BYTES);
        col_term = 18'(col_idx) * 18'(GLYPH_BYTES);
        return row_term + col_term;
    endfunction

endpackage

// ===== sv/gb2312_text_layout_unit.sv =====
// An accepted byte enters the input register; the output register holds its result on m_data.
// One byte per cycle unless m_ready stalls; cursor update is combinational from the input register.
// The output register lets a new byte enter while a result waits for m_ready.
// Reset (aresetn low, synchronous): config registers take their defaults, cursor state clears,
// the string is stopped until a byte with first_of_string arrives, both pipeline stages empty.
module gb2312_text_layout_unit
    import gtl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] left_edge_reg;
    logic [7:0] right_edge_reg;
    logic [7:0] bottom_edge_reg;
    logic [4:0] narrow_width_reg;
    logic [4:0] wide_width_reg;
    logic [5:0] line_height_reg;
    logic [7:0] ascii_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_edge_reg    <= RST_LEFT_EDGE;
            right_edge_reg   <= RST_RIGHT_EDGE;
            bottom_edge_reg  <= RST_BOTTOM_EDGE;
            narrow_width_reg <= RST_NARROW_WIDTH;
            wide_width_reg   <= RST_WIDE_WIDTH;
            line_height_reg  <= RST_LINE_HEIGHT;
            ascii_row_reg    <= RST_ASCII_ROW;
        end else if (cfg_we) begin
            unique case (cfg_reg_e'(cfg_addr))
                CFG_LEFT_EDGE:         left_edge_reg    <= cfg_wdata;
                CFG_RIGHT_EDGE:        right_edge_reg   <= cfg_wdata;
                CFG_BOTTOM_EDGE:       bottom_edge_reg  <= cfg_wdata;
                CFG_NARROW_CELL_WIDTH: narrow_width_reg <= cfg_wdata[4:0];
                CFG_WIDE_CELL_WIDTH:   wide_width_reg   <= cfg_wdata[4:0];
                CFG_LINE_HEIGHT:       line_height_reg  <= cfg_wdata[5:0];
                CFG_ASCII_FONT_ROW:    ascii_row_reg    <= cfg_wdata;
                default: ;   // unused index: write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      advance;     // input stage moves into the output stage
    logic      s_fire;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Text cursor state
    // ------------------------------------------------------------------
    logic [7:0] cursor_x_reg,  cursor_x_next;
    logic [7:0] cursor_y_reg,  cursor_y_next;
    logic       lead_pend_reg, lead_pend_next;
    logic [7:0] lead_byte_reg, lead_byte_next;
    logic       stopped_reg,   stopped_next;

    // Working values once a string start has been applied
    logic [7:0] cx, cy, lb, b;
    logic       lp, stp;

    logic [4:0]  cell_w;
    logic [4:0]  need;
    logic [8:0]  reach;       // rightmost column the character would touch
    logic [8:0]  ny;          // next line y
    logic [9:0]  ny_bottom;   // bottom of the next line
    logic        wraps;
    logic        wrap_halt;
    logic [7:0]  px, py;      // position after a possible wrap

    logic [8:0]  adv_sum;
    logic [7:0]  adv_step;
    logic [7:0]  adv_base;

    logic [7:0]  row_sub, col_sub;
    logic        res_valid;
    out_item_t   res;

    always_comb begin
        cx  = cursor_x_reg;
        cy  = cursor_y_reg;
        lp  = lead_pend_reg;
        lb  = lead_byte_reg;
        stp = stopped_reg;
        b   = in_data_reg.text_byte;
        if (in_data_reg.first_of_string) begin
            cx  = in_data_reg.start_x;
            cy  = in_data_reg.start_y;
            lp  = 1'b0;
            lb  = 8'd0;
            stp = 1'b0;
        end

        // wrap check, shared by narrow chars and lead bytes
        cell_w    = b[7] ? wide_width_reg : narrow_width_reg;
        need      = (cell_w == 5'd0) ? 5'd0 : cell_w - 5'd1;
        reach     = {1'b0, cx} + {4'd0, need};
        ny        = {1'b0, cy} + {3'd0, line_height_reg};
        ny_bottom = {1'b0, ny} + {4'd0, line_height_reg};
        wraps     = reach > {1'b0, right_edge_reg};
        wrap_halt = wraps && (ny_bottom > {2'd0, bottom_edge_reg});
        px        = wraps ? left_edge_reg : cx;
        py        = wraps ? ny[7:0] : cy;

        // cursor advance, saturating
        adv_base = lp ? cx : px;
        adv_step = lp ? WIDE_STEP : NARROW_STEP;
        adv_sum  = {1'b0, adv_base} + {1'b0, adv_step};

        row_sub = 8'd0;
        col_sub = 8'd0;

        cursor_x_next  = cx;
        cursor_y_next  = cy;
        lead_pend_next = lp;
        lead_byte_next = lb;
        stopped_next   = stp;
        res_valid      = 1'b0;
        res            = '0;

        if (stp) begin
            // stopped: byte ignored
        end else if (b == BYTE_END) begin
            stopped_next   = 1'b1;
            lead_pend_next = 1'b0;
        end else if (lp) begin
            // trail byte completes a wide character
            lead_pend_next  = 1'b0;
            row_sub         = lb - GB_BASE;
            col_sub         = b - GB_BASE;
            res_valid       = 1'b1;
            res.draw_x      = cx;
            res.draw_y      = cy;
            res.char_code   = {lb, b};
            res.is_wide     = 1'b1;
            res.blank_glyph = (lb < GB_BASE) || (b < GB_BASE);
            res.glyph_offset = res.blank_glyph ? 18'd0 :
                               glyph_offset_f(row_sub[6:0], col_sub[6:0]);
            cursor_x_next   = adv_sum[8] ? 8'hFF : adv_sum[7:0];
        end else if (b == BYTE_NEWLINE) begin
            cursor_x_next = left_edge_reg;
            if (ny > {1'b0, bottom_edge_reg}) begin
                stopped_next   = 1'b1;
                lead_pend_next = 1'b0;
                res_valid      = 1'b1;
                res.halted     = 1'b1;
            end else begin
                cursor_y_next = ny[7:0];
            end
        end else if (wrap_halt) begin
            cursor_x_next  = left_edge_reg;
            stopped_next   = 1'b1;
            lead_pend_next = 1'b0;
            res_valid      = 1'b1;
            res.halted     = 1'b1;
        end else if (!b[7]) begin
            // narrow character from the full-width ASCII row
            row_sub         = ascii_row_reg - GB_BASE;
            col_sub         = b - ASCII_FIRST;
            res_valid       = 1'b1;
            res.draw_x      = px;
            res.draw_y      = py;
            res.char_code   = {8'd0, b};
            res.blank_glyph = (b <= BYTE_SPACE) || (ascii_row_reg < GB_BASE);
            res.glyph_offset = res.blank_glyph ? 18'd0 :
                               glyph_offset_f(row_sub[6:0], col_sub[6:0]);
            cursor_x_next   = adv_sum[8] ? 8'hFF : adv_sum[7:0];
            cursor_y_next   = py;
        end else begin
            // lead byte: position settled now, character emitted on the trail
            cursor_x_next  = px;
            cursor_y_next  = py;
            lead_pend_next = 1'b1;
            lead_byte_next = b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cursor_x_reg  <= 8'd0;
            cursor_y_reg  <= 8'd0;
            lead_pend_reg <= 1'b0;
            lead_byte_reg <= 8'd0;
            stopped_reg   <= 1'b1;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= res_valid;
                cursor_x_reg  <= cursor_x_next;
                cursor_y_reg  <= cursor_y_next;
                lead_pend_reg <= lead_pend_next;
                lead_byte_reg <= lead_byte_next;
                stopped_reg   <= stopped_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a halt beat carries nothing but the halted flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.halted |->
            m_data.draw_x == 8'd0 && m_data.draw_y == 8'd0 &&
            m_data.char_code == 16'd0 && !m_data.is_wide && !m_data.blank_glyph)
        else $error("halt beat with nonzero fields");

    // a blank glyph never points into the font
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.blank_glyph |-> m_data.glyph_offset == 18'd0)
        else $error("blank glyph with nonzero offset");

    // a wide character always has a lead byte of 0x80 or above
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_wide |-> m_data.char_code[15])
        else $error("wide character without lead byte");

    // a processed halt leaves the string stopped with no pending lead
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid && res.halted |=> stopped_reg && !lead_pend_reg)
        else $error("string not stopped after halt");

endmodule

// ===== bench/tb_top.sv =====
module tb_top
    import gtl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run control
    localparam int STALL_LIMIT = 2000;  // cycles without any beat or register write before giving up
    localparam int SETTLE      = 6;     // drain time after the last result
    localparam int HOLD_AT     = 200;   // result count that triggers the long sink stall
    localparam int HOLD_CYCLES = 180;
    localparam int MAX_REPORTS = 50;
    localparam int PHASE_ITEMS = 135;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;

    gb2312_text_layout_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Layout predictor: register copies, cursor state, expected draws
    // ------------------------------------------------------------------
    logic [7:0] cfg_left   = RST_LEFT_EDGE;
    logic [7:0] cfg_right  = RST_RIGHT_EDGE;
    logic [7:0] cfg_bottom = RST_BOTTOM_EDGE;
    logic [4:0] cfg_narrow = RST_NARROW_WIDTH;
    logic [4:0] cfg_wide   = RST_WIDE_WIDTH;
    logic [5:0] cfg_lh     = RST_LINE_HEIGHT;
    logic [7:0] cfg_row    = RST_ASCII_ROW;

    int unsigned cur_x = 0;
    int unsigned cur_y = 0;
    bit          lead_wait = 1'b0;
    logic [7:0]  lead_code = '0;
    bit          stopped = 1'b1;       // idle until a string is opened

    in_item_t  byte_queue[$];          // beats waiting for the driver
    out_item_t expected_draws[$];      // predicted results, oldest first

    int n_queued = 0;
    int n_sent   = 0;
    int n_draws  = 0;
    int errors   = 0;

    function automatic logic [17:0] font_pos(input int unsigned row, input int unsigned col);
        return 18'((FONT_COLS * (row - int'(GB_BASE)) + (col - int'(GB_BASE))) * GLYPH_BYTES);
    endfunction

    // Wrap check before a character of the given cell width; 1 means the text ran off the bottom.
    // Note the halt test looks one extra line ahead, and sums never wrap.
    function automatic bit wrap_halts(input logic [4:0] cell_w);
        int unsigned need;
        int unsigned ny;
        need = (cell_w == 0) ? 0 : int'(cell_w) - 1;
        if (cur_x + need > cfg_right) begin
            cur_x = cfg_left;
            ny = cur_y + cfg_lh;
            if (ny + cfg_lh > cfg_bottom) return 1'b1;
            cur_y = ny;
        end
        return 1'b0;
    endfunction

    function automatic void advance_x(input int unsigned step);
        cur_x = (cur_x + step > 255) ? 255 : cur_x + step;
    endfunction

    task automatic layout_byte(input in_item_t it);
        logic [7:0] b;
        out_item_t  r;
        b = it.text_byte;
        r = '0;
        if (it.first_of_string) begin
            cur_x = it.start_x;
            cur_y = it.start_y;
            lead_wait = 1'b0;
            lead_code = '0;
            stopped = 1'b0;
        end
        if (stopped) return;
        // zero byte closes the string, even in place of a trail
        if (b == BYTE_END) begin
            stopped = 1'b1;
            lead_wait = 1'b0;
            return;
        end
        // trail byte completes a wide character, whatever its value
        if (lead_wait) begin
            lead_wait = 1'b0;
            r.draw_x = 8'(cur_x);
            r.draw_y = 8'(cur_y);
            r.char_code = {lead_code, b};
            r.is_wide = 1'b1;
            r.blank_glyph = (lead_code < GB_BASE) || (b < GB_BASE);
            if (!r.blank_glyph) r.glyph_offset = font_pos(lead_code, b);
            advance_x(WIDE_STEP);
            expected_draws.push_back(r);
            return;
        end
        if (b == BYTE_NEWLINE) begin
            cur_x = cfg_left;
            if (cur_y + cfg_lh > cfg_bottom) begin
                stopped = 1'b1;
                r.halted = 1'b1;
                expected_draws.push_back(r);
            end else begin
                cur_y = cur_y + cfg_lh;
            end
            return;
        end
        if (b < 8'h80) begin
            if (wrap_halts(cfg_narrow)) begin
                stopped = 1'b1;
                r.halted = 1'b1;
                expected_draws.push_back(r);
                return;
            end
            r.draw_x = 8'(cur_x);
            r.draw_y = 8'(cur_y);
            r.char_code = {8'h00, b};
            r.blank_glyph = (b <= BYTE_SPACE) || (cfg_row < GB_BASE);
            if (!r.blank_glyph)
                r.glyph_offset = font_pos(cfg_row, int'(b) - int'(ASCII_FIRST) + int'(GB_BASE));
            advance_x(NARROW_STEP);
            expected_draws.push_back(r);
            return;
        end
        // lead byte: wrap check now, the result comes with the trail
        if (wrap_halts(cfg_wide)) begin
            stopped = 1'b1;
            r.halted = 1'b1;
            expected_draws.push_back(r);
            return;
        end
        lead_wait = 1'b1;
        lead_code = b;
    endtask

    // ------------------------------------------------------------------
    // Driver: one beat per accepted handshake, random gaps
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_bytes
        bit calm;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                layout_byte(s_data);
                n_sent++;
            end
            calm = (n_sent >= 400) && (n_sent < 560);   // stretch with no gaps
            if (!s_valid || s_ready) begin
                if (byte_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
                    s_valid <= 1'b1;
                    s_data  <= byte_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat, random backpressure, one long hold
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    task automatic check_draw(input out_item_t got);
        out_item_t want;
        n_draws++;
        if (expected_draws.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected result x=%0d y=%0d code=%h wide=%b blank=%b off=%0d halt=%b",
                         $time, got.draw_x, got.draw_y, got.char_code, got.is_wide,
                         got.blank_glyph, got.glyph_offset, got.halted);
            return;
        end
        want = expected_draws.pop_front();
        if (got.draw_x !== want.draw_x || got.draw_y !== want.draw_y ||
            got.char_code !== want.char_code || got.is_wide !== want.is_wide ||
            got.blank_glyph !== want.blank_glyph || got.glyph_offset !== want.glyph_offset ||
            got.halted !== want.halted) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: mismatch, expected x=%0d y=%0d code=%h wide=%b blank=%b off=%0d halt=%b",
                         $time, want.draw_x, want.draw_y, want.char_code, want.is_wide,
                         want.blank_glyph, want.glyph_offset, want.halted);
                $display("%0t:           actual x=%0d y=%0d code=%h wide=%b blank=%b off=%0d halt=%b",
                         $time, got.draw_x, got.draw_y, got.char_code, got.is_wide,
                         got.blank_glyph, got.glyph_offset, got.halted);
            end
        end
    endtask

    always @(posedge aclk) begin : watch_draws
        bit calm;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_draw(m_data);
            calm = (n_draws >= 420) && (n_draws < 540);
            // long hold-off: the pipe fills and s_ready drops while bytes keep coming
            if (!hold_done && n_draws >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Watchdog: any beat or register write restarts the count
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // start_x/start_y are don't-care on continuation beats, so they get random junk
    task automatic queue_byte(input bit first, input logic [7:0] sx, input logic [7:0] sy,
                              input logic [7:0] b);
        in_item_t it;
        it.first_of_string = first;
        it.start_x = first ? sx : 8'($urandom_range(0, 255));
        it.start_y = first ? sy : 8'($urandom_range(0, 255));
        it.text_byte = b;
        byte_queue.push_back(it);
        n_queued++;
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_LEFT_EDGE:         cfg_left   = val;
            CFG_RIGHT_EDGE:        cfg_right  = val;
            CFG_BOTTOM_EDGE:       cfg_bottom = val;
            CFG_NARROW_CELL_WIDTH: cfg_narrow = val[4:0];
            CFG_WIDE_CELL_WIDTH:   cfg_wide   = val[4:0];
            CFG_LINE_HEIGHT:       cfg_lh     = val[5:0];
            CFG_ASCII_FONT_ROW:    cfg_row    = val;
            default: ;
        endcase
    endtask

    task automatic set_layout(input logic [7:0] left, input logic [7:0] right,
                              input logic [7:0] bottom, input logic [7:0] narrow,
                              input logic [7:0] wide, input logic [7:0] lh,
                              input logic [7:0] row);
        write_reg(CFG_LEFT_EDGE, left);
        write_reg(CFG_RIGHT_EDGE, right);
        write_reg(CFG_BOTTOM_EDGE, bottom);
        write_reg(CFG_NARROW_CELL_WIDTH, narrow);
        write_reg(CFG_WIDE_CELL_WIDTH, wide);
        write_reg(CFG_LINE_HEIGHT, lh);
        write_reg(CFG_ASCII_FONT_ROW, row);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly a sane text box, sometimes any edge values the registers allow
    task automatic random_layout();
        if ($urandom_range(0, 99) < 60)
            set_layout(8'($urandom_range(0, 60)), 8'($urandom_range(100, 255)),
                       8'($urandom_range(60, 255)), 8'($urandom_range(1, 16)),
                       8'($urandom_range(1, 16)), 8'($urandom_range(1, 32)),
                       8'($urandom_range(161, 254)));
        else
            set_layout(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(1, 16)),
                       8'($urandom_range(1, 16)), 8'($urandom_range(1, 32)),
                       8'($urandom_range(161, 254)));
    endtask

    // One string: ASCII, spaces, controls, newlines, GB2312 pairs, odd pairs,
    // usually closed by a zero byte; sometimes followed by noise beats.
    task automatic queue_string();
        logic [7:0] text[$];
        logic [7:0] sx;
        logic [7:0] sy;
        int pieces;
        int kind;
        sx = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 160));
        sy = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
        pieces = $urandom_range(1, 30);
        for (int i = 0; i < pieces; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                text.push_back(8'($urandom_range(int'(ASCII_FIRST), 126)));
            end else if (kind < 52) begin
                text.push_back(BYTE_SPACE);
            end else if (kind < 56) begin
                text.push_back(8'($urandom_range(1, 127)));
            end else if (kind < 62) begin
                text.push_back(BYTE_NEWLINE);
            end else if (kind < 88) begin
                text.push_back(8'($urandom_range(int'(GB_BASE), 255)));
                text.push_back(8'($urandom_range(int'(GB_BASE), 255)));
            end else if (kind < 95) begin
                text.push_back(8'($urandom_range(128, 255)));
                text.push_back(8'($urandom_range(1, 255)));
            end else begin
                text.push_back(8'($urandom_range(1, 255)));
            end
        end
        // a dangling lead before the terminator gets dropped
        if ($urandom_range(0, 9) == 0) text.push_back(8'($urandom_range(128, 255)));
        if ($urandom_range(0, 99) < 80) text.push_back(BYTE_END);
        foreach (text[i]) queue_byte(i == 0, sx, sy, text[i]);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                queue_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Block is idle once every beat is in and every result is out; bytes that
    // give no result may still be in flight, so allow the latency on top.
    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_valid || expected_draws.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int target;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, default layout (160x96 box, 6/12 cells)
        queue_byte(1'b0, 8'd0, 8'd0, 8'h41);            // ignored: no string open yet
        queue_byte(1'b1, 8'd0, 8'd0, 8'h41);
        queue_byte(1'b0, 8'd0, 8'd0, 8'h7F);            // one past the last font column
        queue_byte(1'b0, 8'd0, 8'd0, BYTE_SPACE);       // blank
        queue_byte(1'b0, 8'd0, 8'd0, 8'h01);            // control, blank
        queue_byte(1'b0, 8'd0, 8'd0, GB_BASE);          // first glyph of the font
        queue_byte(1'b0, 8'd0, 8'd0, GB_BASE);
        queue_byte(1'b0, 8'd0, 8'd0, 8'hFF);            // highest codes
        queue_byte(1'b0, 8'd0, 8'd0, 8'hFF);
        queue_byte(1'b0, 8'd0, 8'd0, 8'h80);            // lead below the GB range
        queue_byte(1'b0, 8'd0, 8'd0, GB_BASE);
        queue_byte(1'b0, 8'd0, 8'd0, 8'hB0);            // trail below the GB range
        queue_byte(1'b0, 8'd0, 8'd0, 8'h41);
        queue_byte(1'b0, 8'd0, 8'd0, 8'hA5);            // newline taken as a trail
        queue_byte(1'b0, 8'd0, 8'd0, BYTE_NEWLINE);
        queue_byte(1'b0, 8'd0, 8'd0, BYTE_NEWLINE);     // plain newline
        queue_byte(1'b0, 8'd0, 8'd0, 8'hC0);            // lead cut off by terminator
        queue_byte(1'b0, 8'd0, 8'd0, BYTE_END);
        queue_byte(1'b1, 8'd155, 8'd0, 8'h42);          // narrow char wraps
        queue_byte(1'b1, 8'd150, 8'd0, 8'hB0);          // wide char wraps on its lead
        queue_byte(1'b0, 8'd0, 8'd0, 8'hA2);
        queue_byte(1'b1, 8'd0, 8'd90, BYTE_NEWLINE);    // newline runs off the bottom
        queue_byte(1'b0, 8'd0, 8'd0, 8'h43);            // ignored after halt
        queue_byte(1'b1, 8'd158, 8'd72, 8'h41);         // wrap runs off the bottom
        queue_byte(1'b1, 8'd0, 8'd0, BYTE_END);         // empty string
        queue_byte(1'b1, 8'd0, 8'd0, 8'hB1);            // restart drops pending lead
        queue_byte(1'b1, 8'd10, 8'd20, 8'h5A);
        wait_idle();

        // Random phases, each with its own layout
        for (int p = 1; p <= 7; p++) begin
            case (p)
                2: set_layout(8'd0, 8'd255, 8'd255, 8'd1, 8'd1, 8'd1, 8'd161);
                3: set_layout(8'd255, 8'd0, 8'd0, 8'd16, 8'd16, 8'd32, 8'd254);
                4: set_layout(RST_LEFT_EDGE, RST_RIGHT_EDGE, RST_BOTTOM_EDGE,
                              8'(RST_NARROW_WIDTH), 8'(RST_WIDE_WIDTH),
                              8'(RST_LINE_HEIGHT), RST_ASCII_ROW);
                default: random_layout();
            endcase
            @(negedge aclk);
            if (p == 2) begin
                // cursor saturation at the right end of a full-width box
                queue_byte(1'b1, 8'd250, 8'd0, 8'h41);
                queue_byte(1'b0, 8'd0, 8'd0, 8'h42);
                queue_byte(1'b0, 8'd0, 8'd0, GB_BASE);
                queue_byte(1'b0, 8'd0, 8'd0, 8'hB5);
            end
            target = n_queued + PHASE_ITEMS;
            while (n_queued < target) queue_string();
            wait_idle();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gtl_pkg.sv
sv/gb2312_text_layout_unit.sv
bench/tb_top.sv
